### rtl/sac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg
// shared types and constants for the set-associative cache controller
// ----------------------------------------------------------------------------
package sac_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_INDEX_BITS  = 3'd0;
    localparam logic [2:0] REG_OFFSET_BITS = 3'd1;
    localparam logic [2:0] REG_WAYS        = 3'd2;
    localparam logic [2:0] REG_REPLACE_LRU = 3'd3;
    localparam logic [2:0] REG_WRITE_BACK  = 3'd4;
    localparam logic [2:0] REG_HIT_CYCLES  = 3'd5;
    localparam logic [2:0] REG_MEM_CYCLES  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int TAG_W       = 30;
    localparam int STAMP_W     = 32;
    localparam int WAY_IDX_W   = 4;
    localparam int OFFSET_MAX  = 4;

    typedef logic [WAY_IDX_W-1:0] way_idx_t;

    // summary of one set scan
    typedef struct packed {
        logic     hit;
        way_idx_t hit_way;
        logic     hit_dirty;
        logic     found_inv;
        way_idx_t inv_way;
        way_idx_t old_way;
        logic     old_dirty;
    } scan_t;

endpackage
`default_nettype wire

### rtl/sac_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_if
// request and response channels of the cache controller
// ----------------------------------------------------------------------------
interface sac_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] byte_address;

    modport source (output valid, output func, output byte_address, input ready);
    modport sink   (input valid, input func, input byte_address, output ready);
endinterface

interface sac_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [2:0]  way_used;
    logic        evicted_dirty;
    logic [11:0] access_cost;
    logic [31:0] hits_total;
    logic [31:0] misses_total;
    logic [47:0] cycles_total;

    modport source (output valid, output hit, output way_used, output evicted_dirty,
                    output access_cost, output hits_total, output misses_total,
                    output cycles_total, input ready);
    modport sink   (input valid, input hit, input way_used, input evicted_dirty,
                    input access_cost, input hits_total, input misses_total,
                    input cycles_total, output ready);
endinterface
`default_nettype wire

### rtl/set_assoc_cache_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_controller_unit
// set-associative tag controller with lru/fifo replacement and cost counters
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | func, byte_address
//  rsp     | out | hit, way_used, evicted_dirty, access_cost, totals
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
//  a request is taken only in idle; the scan issues one way per cycle to the
//  tag and flag rams, waits for the last read to return and for the scan
//  result to settle, then the update step writes the flag ram, writes the
//  tag ram on a miss or under lru, and loads the response register; the
//  next request is taken only once the update step has finished
//  after reset a clearing pass over all lines (MAX_SETS * MAX_WAYS, 2048 by
//  default) zeroes the valid/dirty flag ram with ready low
//  a stalled response holds the update step and with it the input
// ----------------------------------------------------------------------------
module set_assoc_cache_controller_unit #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    sac_req_if.sink                                  req,
    sac_rsp_if.source                                rsp,
    input  wire logic                                cfg_we,
    input  wire logic [sac_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sac_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int LOG2_SETS = $clog2(MAX_SETS);
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W     = $clog2(MAX_WAYS + 1);
    localparam int LINES     = MAX_SETS * MAX_WAYS;
    localparam int ADDR_W    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int ENTRY_W   = sac_pkg::TAG_W + sac_pkg::STAMP_W;
    localparam logic [ADDR_W-1:0] WAYS_A    = ADDR_W'(MAX_WAYS);
    localparam logic [ADDR_W-1:0] LAST_LINE = ADDR_W'(LINES - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_CLEAR  = 2'd3;

    // configuration registers
    logic [3:0] index_bits_reg;
    logic [2:0] offset_bits_reg;
    logic [3:0] ways_cfg_reg;
    logic       lru_reg;
    logic       wb_reg;
    logic [7:0] hit_cyc_reg;
    logic [9:0] mem_cyc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg  <= 4'd4;
            offset_bits_reg <= 3'd0;
            ways_cfg_reg    <= 4'd2;
            lru_reg         <= 1'b1;
            wb_reg          <= 1'b1;
            hit_cyc_reg     <= 8'd1;
            mem_cyc_reg     <= 10'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sac_pkg::REG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                sac_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg_data[2:0];
                sac_pkg::REG_WAYS:        ways_cfg_reg    <= cfg_data[3:0];
                sac_pkg::REG_REPLACE_LRU: lru_reg         <= cfg_data[0];
                sac_pkg::REG_WRITE_BACK:  wb_reg          <= cfg_data[0];
                sac_pkg::REG_HIT_CYCLES:  hit_cyc_reg     <= cfg_data[7:0];
                sac_pkg::REG_MEM_CYCLES:  mem_cyc_reg     <= cfg_data[9:0];
                default:                  ;
            endcase
        end
    end

    // address split on accept, with clamped geometry
    logic [3:0]                 ib_c;
    logic [2:0]                 ob_c;
    logic [CNT_W-1:0]           ways_c;
    logic [29:0]                word;
    logic [29:0]                set_mask;
    logic [SET_W-1:0]           set_in;
    logic [sac_pkg::TAG_W-1:0]  tag_in;

    always_comb
    begin
        ib_c = (32'(index_bits_reg) > LOG2_SETS) ? 4'(LOG2_SETS) : index_bits_reg;
        ob_c = (32'(offset_bits_reg) > sac_pkg::OFFSET_MAX) ? 3'(sac_pkg::OFFSET_MAX)
                                                           : offset_bits_reg;
        if (ways_cfg_reg == 4'd0)
            ways_c = CNT_W'(1);
        else if (32'(ways_cfg_reg) > MAX_WAYS)
            ways_c = CNT_W'(MAX_WAYS);
        else
            ways_c = CNT_W'(ways_cfg_reg);
        word     = req.byte_address[31:2] >> ob_c;
        set_mask = (30'(1) << ib_c) - 30'(1);
        set_in   = SET_W'(word & set_mask);
        tag_in   = word >> ib_c;
    end

    // request state
    logic [1:0]                 state_reg, state_next;
    logic                       func_reg;
    logic [SET_W-1:0]           set_reg;
    logic [sac_pkg::TAG_W-1:0]  tag_reg;
    logic [CNT_W-1:0]           ways_reg;
    logic [CNT_W-1:0]           issue_reg, issue_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [WAY_W-1:0]           rd_way_reg;
    logic [sac_pkg::STAMP_W-1:0] seq_reg;
    logic [ADDR_W-1:0]          clr_reg;

    // statistics
    logic [31:0] hits_reg;
    logic [31:0] misses_reg;
    logic [47:0] cycles_reg;

    // tag/stamp ram
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    sac_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // valid/dirty flag ram, bit 1 valid, bit 0 dirty
    logic                 flag_we;
    logic [ADDR_W-1:0]    flag_waddr;
    logic [1:0]           flag_wdata;
    logic [1:0]           flag_rdata;

    sac_ram #(
        .WIDTH (2),
        .DEPTH (LINES)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (ram_raddr),
        .rdata (flag_rdata)
    );

    logic            accept;
    logic            scan_clear;
    sac_pkg::scan_t  scan;

    assign accept     = req.valid && req.ready;
    assign scan_clear = accept;

    sac_way_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (scan_clear),
        .step       (rd_vld_reg),
        .way        (sac_pkg::WAY_IDX_W'(rd_way_reg)),
        .line_valid (flag_rdata[1]),
        .line_dirty (flag_rdata[0]),
        .line_tag   (ram_rdata[ENTRY_W-1:sac_pkg::STAMP_W]),
        .line_stamp (ram_rdata[sac_pkg::STAMP_W-1:0]),
        .tag        (tag_reg),
        .seq        (seq_reg),
        .result     (scan)
    );

    // update decision
    logic              out_free;
    logic              do_update;
    logic [WAY_W-1:0]  way_sel;
    logic              evict;
    logic              dirty_new;
    logic [11:0]       cost;
    logic [11:0]       mem_ext;
    logic [48:0]       cyc_sum;

    assign out_free  = !rsp.valid || rsp.ready;
    assign do_update = (state_reg == S_UPDATE) && out_free;
    assign mem_ext   = 12'(mem_cyc_reg);

    always_comb
    begin
        if (scan.hit)
            way_sel = WAY_W'(scan.hit_way);
        else if (scan.found_inv)
            way_sel = WAY_W'(scan.inv_way);
        else
            way_sel = WAY_W'(scan.old_way);
        evict = !scan.hit && !scan.found_inv && wb_reg && scan.old_dirty;
        // a write hit under write-back sets dirty, a fill starts clean unless
        // it is a write-allocate under write-back
        if (scan.hit)
            dirty_new = scan.hit_dirty || (func_reg && wb_reg);
        else
            dirty_new = func_reg && wb_reg;
        cost  = 12'(hit_cyc_reg);
        if (scan.hit)
        begin
            if (func_reg && !wb_reg)
                cost = cost + mem_ext;
        end
        else
        begin
            cost = cost + mem_ext;
            if (evict)
                cost = cost + mem_ext;
        end
        cyc_sum = {1'b0, cycles_reg} + 49'(cost);
    end

    assign ram_we    = do_update && (!scan.hit || lru_reg);
    assign ram_waddr = ADDR_W'(set_reg) * WAYS_A + ADDR_W'(way_sel);
    assign ram_wdata = {tag_reg, seq_reg};
    assign ram_raddr = ADDR_W'(set_reg) * WAYS_A + ADDR_W'(issue_reg);

    // clearing pass after reset, then one flag write per update
    assign flag_we    = (state_reg == S_CLEAR) || do_update;
    assign flag_waddr = (state_reg == S_CLEAR) ? clr_reg : ram_waddr;
    assign flag_wdata = (state_reg == S_CLEAR) ? 2'b00 : {1'b1, dirty_new};

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        issue_next  = issue_reg;
        rd_vld_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    issue_next = '0;
                end
            end
            S_SCAN:
            begin
                if (issue_reg < ways_reg)
                begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                if (clr_reg == LAST_LINE)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            issue_reg  <= '0;
            rd_vld_reg <= 1'b0;
            seq_reg    <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            cycles_reg <= '0;
            rsp.valid  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issue_reg  <= issue_next;
            rd_vld_reg <= rd_vld_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + ADDR_W'(1);
            if (do_update)
                rsp.valid <= 1'b1;
            else if (rsp.valid && rsp.ready)
                rsp.valid <= 1'b0;
            if (do_update)
            begin
                seq_reg    <= seq_reg + 32'd1;
                cycles_reg <= cyc_sum[48] ? '1 : cyc_sum[47:0];
                if (scan.hit)
                begin
                    if (hits_reg != '1)
                        hits_reg <= hits_reg + 32'd1;
                end
                else
                begin
                    if (misses_reg != '1)
                        misses_reg <= misses_reg + 32'd1;
                end
            end
        end
    end

    // request payload and read pipeline, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            set_reg  <= set_in;
            tag_reg  <= tag_in;
            ways_reg <= ways_c;
        end
        rd_way_reg <= WAY_W'(issue_reg);
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (do_update)
        begin
            rsp.hit           <= scan.hit;
            rsp.way_used      <= 3'(way_sel);
            rsp.evicted_dirty <= evict;
            rsp.access_cost   <= cost;
            rsp.hits_total    <= (scan.hit && hits_reg != '1) ? hits_reg + 32'd1
                                                               : hits_reg;
            rsp.misses_total  <= (!scan.hit && misses_reg != '1) ? misses_reg + 32'd1
                                                                  : misses_reg;
            rsp.cycles_total  <= cyc_sum[48] ? '1 : cyc_sum[47:0];
        end
    end

endmodule
`default_nettype wire

### rtl/sac_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

### rtl/sac_way_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_way_scan
// shared compare unit: looks at one way a cycle while step is high and keeps hit, free and oldest
// ----------------------------------------------------------------------------
module sac_way_scan (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            clear,
    input  wire logic                            step,
    input  wire sac_pkg::way_idx_t               way,
    input  wire logic                            line_valid,
    input  wire logic                            line_dirty,
    input  wire logic [sac_pkg::TAG_W-1:0]       line_tag,
    input  wire logic [sac_pkg::STAMP_W-1:0]     line_stamp,
    input  wire logic [sac_pkg::TAG_W-1:0]       tag,
    input  wire logic [sac_pkg::STAMP_W-1:0]     seq,
    output sac_pkg::scan_t                       result
);

    sac_pkg::scan_t               res_reg, res_next;
    logic [sac_pkg::STAMP_W-1:0]  best_reg, best_next;
    logic [sac_pkg::STAMP_W-1:0]  age;

    assign age = seq - line_stamp;

    always_comb
    begin
        res_next  = res_reg;
        best_next = best_reg;
        if (clear)
        begin
            res_next  = '0;
            best_next = '0;
        end
        else if (step)
        begin
            if (line_valid && line_tag == tag && !res_reg.hit)
            begin
                res_next.hit       = 1'b1;
                res_next.hit_way   = way;
                res_next.hit_dirty = line_dirty;
            end
            if (!line_valid && !res_reg.found_inv)
            begin
                res_next.found_inv = 1'b1;
                res_next.inv_way   = way;
            end
            // ties keep the lower way
            if (way == '0 || age > best_reg)
            begin
                best_next          = age;
                res_next.old_way   = way;
                res_next.old_dirty = line_dirty;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign result = res_reg;

endmodule
`default_nettype wire

### sim/set_assoc_cache_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_controller_unit_tb
// self-checking bench for the set-associative cache tag controller: a
// directed run on the reset settings, then random accesses over several
// register settings, each result checked against a behavioral cache model
// ----------------------------------------------------------------------------
module set_assoc_cache_controller_unit_tb;

    localparam int SET_COUNT  = 256;
    localparam int WAY_COUNT  = 8;
    localparam int IDLE_LIMIT = 10000;  // cycles with no handshake before giving up
    localparam int HOLD_OFF   = 400;    // long response stall

    // one lookup result as the block reports it
    typedef struct packed {
        logic        hit;
        logic [2:0]  way_used;
        logic        evicted_dirty;
        logic [11:0] access_cost;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
        logic [47:0] cycles_total;
    } lookup_t;

    // ------------------------------------------------------------------------
    // cache model and result queue
    // ------------------------------------------------------------------------
    class cache_scoreboard;
        bit [3:0]  index_bits;
        bit [2:0]  offset_bits;
        bit [3:0]  ways_cfg;
        bit        use_lru;
        bit        write_back;
        bit [7:0]  hit_cycles;
        bit [9:0]  mem_cycles;
        bit        line_valid[SET_COUNT*WAY_COUNT];
        bit        line_dirty[SET_COUNT*WAY_COUNT];
        bit [29:0] line_tag[SET_COUNT*WAY_COUNT];
        bit [31:0] line_stamp[SET_COUNT*WAY_COUNT];
        bit [31:0] access_seq;
        bit [31:0] hits_seen;
        bit [31:0] misses_seen;
        bit [47:0] cycle_count;
        lookup_t   pending[$];
        int        errors;

        function new();
            index_bits = 4; offset_bits = 0; ways_cfg = 2; use_lru = 1;
            write_back = 1; hit_cycles = 1; mem_cycles = 100;
            foreach (line_valid[i])
            begin
                line_valid[i] = 0;
                line_dirty[i] = 0;
            end
            access_seq = 0; hits_seen = 0; misses_seen = 0; cycle_count = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [9:0] data);
            case (idx)
                sac_pkg::REG_INDEX_BITS:  index_bits  = data[3:0];
                sac_pkg::REG_OFFSET_BITS: offset_bits = data[2:0];
                sac_pkg::REG_WAYS:        ways_cfg    = data[3:0];
                sac_pkg::REG_REPLACE_LRU: use_lru     = data[0];
                sac_pkg::REG_WRITE_BACK:  write_back  = data[0];
                sac_pkg::REG_HIT_CYCLES:  hit_cycles  = data[7:0];
                sac_pkg::REG_MEM_CYCLES:  mem_cycles  = data[9:0];
                default: ;
            endcase
        endfunction

        // look one access up, update the lines and queue the expected result
        function void note_request(bit is_write, bit [31:0] addr);
            int        ib, ob, nways, base, way, w;
            bit [31:0] word, set_idx, tag, age, best_age;
            bit [31:0] cost;
            bit [48:0] sum;
            bit        hit, evicted, found;
            lookup_t   r;
            ib    = (index_bits > 8) ? 8 : index_bits;
            ob    = (offset_bits > sac_pkg::OFFSET_MAX) ? sac_pkg::OFFSET_MAX : offset_bits;
            nways = (ways_cfg == 0) ? 1 : ((ways_cfg > WAY_COUNT) ? WAY_COUNT : ways_cfg);
            word    = (addr >> 2) >> ob;
            set_idx = word & ((32'd1 << ib) - 1);
            tag     = word >> ib;
            base    = set_idx * WAY_COUNT;
            hit = 0; evicted = 0; way = 0;
            for (w = 0; w < nways; w++)
            begin
                if (!hit && line_valid[base+w] && line_tag[base+w] == tag[29:0])
                begin
                    hit = 1;
                    way = w;
                end
            end
            cost = hit_cycles;
            if (hit)
            begin
                if (use_lru)
                    line_stamp[base+way] = access_seq;
                if (is_write)
                begin
                    if (write_back)
                        line_dirty[base+way] = 1;
                    else
                        cost += mem_cycles;
                end
                if (hits_seen != 32'hFFFF_FFFF)
                    hits_seen++;
            end
            else
            begin
                found = 0;
                for (w = 0; w < nways; w++)
                begin
                    if (!found && !line_valid[base+w])
                    begin
                        found = 1;
                        way = w;
                    end
                end
                if (!found)
                begin
                    // oldest stamp wins, lowest way on a tie
                    best_age = 0;
                    for (w = 0; w < nways; w++)
                    begin
                        age = access_seq - line_stamp[base+w];
                        if (w == 0 || age > best_age)
                        begin
                            best_age = age;
                            way = w;
                        end
                    end
                    if (write_back && line_dirty[base+way])
                    begin
                        evicted = 1;
                        cost += mem_cycles;
                    end
                end
                cost += mem_cycles;
                line_valid[base+way] = 1;
                line_tag[base+way]   = tag[29:0];
                line_stamp[base+way] = access_seq;
                line_dirty[base+way] = is_write && write_back;
                if (misses_seen != 32'hFFFF_FFFF)
                    misses_seen++;
            end
            access_seq++;
            sum = cycle_count + cost;
            cycle_count = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
            r.hit = hit;
            r.way_used = way[2:0];
            r.evicted_dirty = evicted;
            r.access_cost = cost[11:0];
            r.hits_total = hits_seen;
            r.misses_total = misses_seen;
            r.cycles_total = cycle_count;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(lookup_t act);
            lookup_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got hit=%0b way=%0d",
                         $time, act.hit, act.way_used);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            compare_field("hit", exp_r.hit, act.hit);
            compare_field("way_used", exp_r.way_used, act.way_used);
            compare_field("evicted_dirty", exp_r.evicted_dirty, act.evicted_dirty);
            compare_field("access_cost", exp_r.access_cost, act.access_cost);
            compare_field("hits_total", exp_r.hits_total, act.hits_total);
            compare_field("misses_total", exp_r.misses_total, act.misses_total);
            compare_field("cycles_total", exp_r.cycles_total, act.cycles_total);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sac_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data;

    sac_req_if req ();
    sac_rsp_if rsp ();

    set_assoc_cache_controller_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cache_scoreboard sb;
    int              idle_cycles;
    int              burst_left;
    bit              gaps_on;
    bit              hold_request;
    logic [31:0]     hot_addr[16];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // response side: check every accepted response
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result({rsp.hit, rsp.way_used, rsp.evicted_dirty, rsp.access_cost,
                             rsp.hits_total, rsp.misses_total, rsp.cycles_total});
    end

    // receiver stall pattern, with one long hold-off on demand
    initial
    begin : receiver
        int cyc;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // keep the response blocked so the block backs up into its input
                rsp.ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                hold_request = 0;
            end
            cyc++;
            case ((cyc / 64) % 4)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= 1'($urandom_range(0, 1));
                2:       rsp.ready <= ($urandom_range(0, 3) == 0);
                default: rsp.ready <= (cyc % 8) < 5;
            endcase
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("set_assoc_cache_controller_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [9:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one access; bursts of back-to-back requests separated by random gaps
    task automatic send_access(bit is_write, logic [31:0] addr);
        @(negedge clk);
        if (gaps_on && burst_left == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0)
            burst_left--;
        req.valid        <= 1'b1;
        req.func         <= is_write;
        req.byte_address <= addr;
        do
            @(posedge clk);
        while (!(req.valid && req.ready));
        sb.note_request(is_write, addr);
    endtask

    // stop offering requests and let every expected response drain
    task automatic drain();
        @(negedge clk);
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // extra margin before the registers are rewritten
        repeat (20) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_config(int ib, int ob, int nw, int lru, int wb, int hc, int mc);
        drain();
        write_reg(sac_pkg::REG_INDEX_BITS, 10'(ib));
        write_reg(sac_pkg::REG_OFFSET_BITS, 10'(ob));
        write_reg(sac_pkg::REG_WAYS, 10'(nw));
        write_reg(sac_pkg::REG_REPLACE_LRU, 10'(lru));
        write_reg(sac_pkg::REG_WRITE_BACK, 10'(wb));
        write_reg(sac_pkg::REG_HIT_CYCLES, 10'(hc));
        write_reg(sac_pkg::REG_MEM_CYCLES, 10'(mc));
    endtask

    // mostly a small pool of hot lines so that hits and evictions happen,
    // the rest fully random addresses
    task automatic random_accesses(int count);
        logic [31:0] addr;
        foreach (hot_addr[i])
        begin
            if ($urandom_range(0, 3) == 0)
                hot_addr[i] = $urandom;
            else
                hot_addr[i] = ($urandom_range(0, 3) << 14) | ($urandom & 32'h3FFF);
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                addr = hot_addr[$urandom_range(0, 15)] ^ $urandom_range(0, 3);
            else
                addr = $urandom;
            send_access(1'($urandom_range(0, 1)), addr);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        req.valid        = 1'b0;
        req.func         = 1'b0;
        req.byte_address = '0;
        rsp.ready        = 1'b0;
        idle_cycles      = 0;
        burst_left       = 0;
        gaps_on          = 1;
        hold_request     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 16 sets, 2 ways, lru, write-back; set 0 holds tag << 6
        send_access(0, 32'h0000_0000);  // cold miss
        send_access(0, 32'h0000_0003);  // read hit, byte bits ignored
        send_access(1, 32'h0000_0000);  // write hit marks dirty
        send_access(0, 32'h0000_0040);  // fills second way
        send_access(0, 32'h0000_0080);  // evicts the dirty oldest line
        send_access(0, 32'h0000_0040);  // hit refreshes stamp
        send_access(1, 32'h0000_00C0);  // write miss allocates dirty
        send_access(0, 32'h0000_0000);  // evicts clean line
        send_access(1, 32'hFFFF_FFFF);
        send_access(0, 32'hFFFF_FFFC);
        send_access(1, 32'h8000_0000);
        send_access(0, 32'h7FFF_FFFC);
        send_access(0, 32'hAAAA_AAAA);
        send_access(1, 32'h5555_5555);
        random_accesses(100);

        // largest geometry and costs, with a long response stall
        set_config(8, 4, 8, 1, 1, 255, 1023);
        hold_request = 1;
        random_accesses(120);

        // one set, one way, fifo, write-through, zero costs; no gaps
        set_config(0, 0, 1, 0, 0, 0, 0);
        gaps_on = 0;
        random_accesses(100);
        gaps_on = 1;

        // out-of-range index, offset and way count are clamped
        set_config(15, 7, 0, 0, 1, 3, 17);
        random_accesses(100);

        // way count above the maximum, write-through lru
        set_config(2, 1, 15, 1, 0, 1, 1);
        random_accesses(100);

        // fifo write-back with random costs; pause for a full drain mid-way
        set_config(3, 2, 4, 0, 1, $urandom_range(1, 255), $urandom_range(1, 1023));
        random_accesses(60);
        drain();
        random_accesses(60);

        drain();
        if (sb.errors == 0)
            $display("set_assoc_cache_controller_unit test passed");
        else
            $display("set_assoc_cache_controller_unit test failed");
        $finish;
    end

endmodule
